@@ rtl/pru_pkg.sv @@
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, constants and helpers of the permutation rank/unrank core.
// ----------------------------------------------------------------------------
package pru_pkg;

    localparam int NUM_ELEMS  = 9;
    localparam int ELEM_W     = 4;
    localparam int RANK_W     = 19;
    localparam int CNT_W      = 4;
    localparam int IDX_W      = $clog2(NUM_ELEMS);
    localparam int PIPE_DEPTH = NUM_ELEMS;
    localparam int RANK_STG   = 4;

    typedef enum logic {
        OP_RANK   = 1'b0,
        OP_UNRANK = 1'b1
    } t_op;

    typedef logic [ELEM_W-1:0]    t_elem;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [NUM_ELEMS-1:0] t_mask;

    typedef struct packed {
        t_op                      op;
        logic                     err;
        t_rank                    rem;
        t_mask                    used;
        t_elem [NUM_ELEMS-1:0]    elem;
    } t_unrank_st;

    function automatic t_rank fact(input int n);
        int f;
        f = 1;
        for (int k = 2; k <= n; k++) begin
            f = f * k;
        end
        return t_rank'(f);
    endfunction

    localparam t_rank MAX_RANK = t_rank'(int'(fact(NUM_ELEMS)) - 1);

endpackage

@@ rtl/pru_in_if.sv @@
// ----------------------------------------------------------------------------
// pru_in_if
// Request channel: operation, rank and nine elements per beat.
// ----------------------------------------------------------------------------
interface pru_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [pru_pkg::RANK_W-1:0]  rank_in;
    logic [pru_pkg::ELEM_W-1:0]  elem0_in;
    logic [pru_pkg::ELEM_W-1:0]  elem1_in;
    logic [pru_pkg::ELEM_W-1:0]  elem2_in;
    logic [pru_pkg::ELEM_W-1:0]  elem3_in;
    logic [pru_pkg::ELEM_W-1:0]  elem4_in;
    logic [pru_pkg::ELEM_W-1:0]  elem5_in;
    logic [pru_pkg::ELEM_W-1:0]  elem6_in;
    logic [pru_pkg::ELEM_W-1:0]  elem7_in;
    logic [pru_pkg::ELEM_W-1:0]  elem8_in;

    modport source (
        output valid, operation, rank_in,
        output elem0_in, elem1_in, elem2_in, elem3_in, elem4_in,
        output elem5_in, elem6_in, elem7_in, elem8_in,
        input  ready
    );

    modport sink (
        input  valid, operation, rank_in,
        input  elem0_in, elem1_in, elem2_in, elem3_in, elem4_in,
        input  elem5_in, elem6_in, elem7_in, elem8_in,
        output ready
    );
endinterface

@@ rtl/pru_out_if.sv @@
// ----------------------------------------------------------------------------
// pru_out_if
// Result channel: rank, nine elements and error flag per beat.
// ----------------------------------------------------------------------------
interface pru_out_if;
    logic                        valid;
    logic                        ready;
    logic [pru_pkg::RANK_W-1:0]  rank_out;
    logic [pru_pkg::ELEM_W-1:0]  elem0_out;
    logic [pru_pkg::ELEM_W-1:0]  elem1_out;
    logic [pru_pkg::ELEM_W-1:0]  elem2_out;
    logic [pru_pkg::ELEM_W-1:0]  elem3_out;
    logic [pru_pkg::ELEM_W-1:0]  elem4_out;
    logic [pru_pkg::ELEM_W-1:0]  elem5_out;
    logic [pru_pkg::ELEM_W-1:0]  elem6_out;
    logic [pru_pkg::ELEM_W-1:0]  elem7_out;
    logic [pru_pkg::ELEM_W-1:0]  elem8_out;
    logic                        rank_error;

    modport source (
        output valid, rank_out, rank_error,
        output elem0_out, elem1_out, elem2_out, elem3_out, elem4_out,
        output elem5_out, elem6_out, elem7_out, elem8_out,
        input  ready
    );

    modport sink (
        input  valid, rank_out, rank_error,
        input  elem0_out, elem1_out, elem2_out, elem3_out, elem4_out,
        input  elem5_out, elem6_out, elem7_out, elem8_out,
        output ready
    );
endinterface

@@ rtl/pru_rank.sv @@
// ----------------------------------------------------------------------------
// pru_rank
// Rank datapath: inversion counts, factorial weights, two-level adder tree,
// then delay stages to line up with the unrank pipe.
// ----------------------------------------------------------------------------
module pru_rank (
    input  logic                                 i_clk,
    input  logic [pru_pkg::PIPE_DEPTH-1:0]       i_en,
    input  pru_pkg::t_elem [pru_pkg::NUM_ELEMS-1:0] i_elem,
    output pru_pkg::t_rank                       o_rank
);

    localparam int N     = pru_pkg::NUM_ELEMS;
    localparam int GRP   = 3;
    localparam int NGRP  = (N + GRP - 1) / GRP;
    localparam int DLY   = pru_pkg::PIPE_DEPTH - pru_pkg::RANK_STG;

    pru_pkg::t_cnt  n_cnt  [N];
    pru_pkg::t_cnt  r_cnt  [N];
    pru_pkg::t_rank n_prod [N];
    pru_pkg::t_rank r_prod [N];
    pru_pkg::t_rank n_part [NGRP];
    pru_pkg::t_rank r_part [NGRP];
    pru_pkg::t_rank n_sum;
    pru_pkg::t_rank r_sum;
    pru_pkg::t_rank r_dly  [DLY];

    // smaller elements to the right of each position
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_cnt[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (j > i && i_elem[j] < i_elem[i]) begin
                    n_cnt[i] = n_cnt[i] + pru_pkg::t_cnt'(1);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_prod[i] = pru_pkg::t_rank'(int'(r_cnt[i]) * int'(pru_pkg::fact(N - 1 - i)));
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < N) begin
                    n_part[g] = n_part[g] + r_prod[g * GRP + k];
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum = n_sum + r_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cnt <= n_cnt;
        end
        if (i_en[1]) begin
            r_prod <= n_prod;
        end
        if (i_en[2]) begin
            r_part <= n_part;
        end
        if (i_en[3]) begin
            r_sum <= n_sum;
        end
        for (int d = 0; d < DLY; d++) begin
            if (i_en[pru_pkg::RANK_STG + d]) begin
                r_dly[d] <= (d == 0) ? r_sum : r_dly[(d == 0) ? 0 : d - 1];
            end
        end
    end

    assign o_rank = r_dly[DLY-1];

endmodule

@@ rtl/pru_unrank_stage.sv @@
// ----------------------------------------------------------------------------
// pru_unrank_stage
// One factoradic digit: divide the remainder by (N-1-POS)!, pick the
// digit-th unused element, register the updated state.
// ----------------------------------------------------------------------------
module pru_unrank_stage #(
    parameter int POS = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  pru_pkg::t_unrank_st i_st,
    output pru_pkg::t_unrank_st o_st
);

    localparam int             N       = pru_pkg::NUM_ELEMS;
    localparam int             REM_LEN = N - 1 - POS;
    localparam pru_pkg::t_rank F       = pru_pkg::fact(REM_LEN);

    pru_pkg::t_cnt                  w_digit;
    pru_pkg::t_cnt                  w_seen;
    logic [pru_pkg::IDX_W-1:0]      w_pick;
    logic                           w_found;
    pru_pkg::t_unrank_st            n_st;
    pru_pkg::t_unrank_st            r_st;

    // quotient by compare against multiples 1..REM_LEN of F
    always_comb begin
        w_digit = '0;
        for (int m = 1; m < N; m++) begin
            if (m <= REM_LEN && i_st.rem >= pru_pkg::t_rank'(m * int'(F))) begin
                w_digit = w_digit + pru_pkg::t_cnt'(1);
            end
        end
    end

    always_comb begin
        w_seen  = '0;
        w_pick  = '0;
        w_found = 1'b0;
        for (int j = 0; j < N; j++) begin
            if (!i_st.used[j] && !w_found) begin
                if (w_seen == w_digit) begin
                    w_pick  = pru_pkg::IDX_W'(j);
                    w_found = 1'b1;
                end else begin
                    w_seen = w_seen + pru_pkg::t_cnt'(1);
                end
            end
        end
    end

    always_comb begin
        n_st              = i_st;
        n_st.rem          = i_st.rem - pru_pkg::t_rank'(int'(w_digit) * int'(F));
        n_st.used[w_pick] = 1'b1;
        n_st.elem[POS]    = pru_pkg::t_elem'({1'b0, w_pick} + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

@@ rtl/permutation_rank_unrank_core.sv @@
// ----------------------------------------------------------------------------
// permutation_rank_unrank_core
// Lexicographic rank <-> nine-element permutation converter.
//
// Usage: a request beat on i_in carries the operation, a rank and nine
// elements. Rank mode returns the Cantor rank of the elements in rank_out.
// Unrank mode returns the permutation of rank_in on elem0_out..elem8_out,
// or all-zero elements with rank_error set when rank_in exceeds 362879.
// Every request gives exactly one result beat on o_out, in order.
// Latency: 9 register stages; the result of an accepted beat passes through
// every stage before it is on o_out.
// Throughput: one beat per cycle while o_out is not stalled; each unrank stage resolves one factoradic
// digit, the rank path is count / weight / two adder levels / delay.
// Reset: clears the stage valid bits; the pipe is empty and ready after it.
// Stall: a low o_out.ready freezes only the full stages with no empty stage
// ahead of them; every other stage still advances, so i_in.ready stays high
// until every stage holds a beat.
// ----------------------------------------------------------------------------
module permutation_rank_unrank_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pru_in_if.sink     i_in,
    pru_out_if.source  o_out
);

    localparam int D = pru_pkg::PIPE_DEPTH;
    localparam int N = pru_pkg::NUM_ELEMS;

    logic [D-1:0]                  r_vld;
    logic [D-1:0]                  n_vld;
    logic [D-1:0]                  w_en;
    pru_pkg::t_elem [N-1:0]        w_elem_in;
    pru_pkg::t_unrank_st           w_st [D+1];
    pru_pkg::t_unrank_st           w_last;
    pru_pkg::t_rank                w_rank;
    logic                          w_ok;
    logic [N-1:0]                  w_present;

    assign w_elem_in[0] = i_in.elem0_in;
    assign w_elem_in[1] = i_in.elem1_in;
    assign w_elem_in[2] = i_in.elem2_in;
    assign w_elem_in[3] = i_in.elem3_in;
    assign w_elem_in[4] = i_in.elem4_in;
    assign w_elem_in[5] = i_in.elem5_in;
    assign w_elem_in[6] = i_in.elem6_in;
    assign w_elem_in[7] = i_in.elem7_in;
    assign w_elem_in[8] = i_in.elem8_in;

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        w_en[D-1] = !r_vld[D-1] || o_out.ready;
        for (int k = D - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign n_vld      = {r_vld[D-2:0], i_in.valid};
    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < D; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_comb begin
        w_st[0]      = '0;
        w_st[0].op   = pru_pkg::t_op'(i_in.operation);
        w_st[0].rem  = i_in.rank_in;
        w_st[0].err  = (pru_pkg::t_op'(i_in.operation) == pru_pkg::OP_UNRANK) &&
                       (i_in.rank_in > pru_pkg::MAX_RANK);
    end

    for (genvar g = 0; g < D; g++) begin : g_unrank
        pru_unrank_stage #(
            .POS (g)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (w_en[g]),
            .i_st  (w_st[g]),
            .o_st  (w_st[g+1])
        );
    end

    pru_rank u_rank (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_elem (w_elem_in),
        .o_rank (w_rank)
    );

    assign w_last = w_st[D];
    assign w_ok   = (w_last.op == pru_pkg::OP_UNRANK) && !w_last.err;

    assign o_out.valid      = r_vld[D-1];
    assign o_out.rank_out   = (w_last.op == pru_pkg::OP_RANK) ? w_rank : '0;
    assign o_out.rank_error = w_last.err;
    assign o_out.elem0_out  = w_ok ? w_last.elem[0] : '0;
    assign o_out.elem1_out  = w_ok ? w_last.elem[1] : '0;
    assign o_out.elem2_out  = w_ok ? w_last.elem[2] : '0;
    assign o_out.elem3_out  = w_ok ? w_last.elem[3] : '0;
    assign o_out.elem4_out  = w_ok ? w_last.elem[4] : '0;
    assign o_out.elem5_out  = w_ok ? w_last.elem[5] : '0;
    assign o_out.elem6_out  = w_ok ? w_last.elem[6] : '0;
    assign o_out.elem7_out  = w_ok ? w_last.elem[7] : '0;
    assign o_out.elem8_out  = w_ok ? w_last.elem[8] : '0;

    // which element values appear on the result beat
    always_comb begin
        w_present = '0;
        for (int i = 0; i < N; i++) begin
            if (w_ok && w_last.elem[i] != '0 && int'(w_last.elem[i]) <= N) begin
                w_present[int'(w_last.elem[i]) - 1] = 1'b1;
            end
        end
    end

    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted beat not captured in first stage");

    a_ready_on_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> i_in.ready)
        else $error("input stalled while a stage is empty");

    a_unrank_perm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && w_ok) |-> (&w_present))
        else $error("unrank result is not a permutation");

    a_rank_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && w_last.op == pru_pkg::OP_RANK) |->
        (!o_out.rank_error && w_present == '0 && o_out.rank_out <= pru_pkg::MAX_RANK))
        else $error("rank result out of range or with element data");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the permutation rank/unrank core against a behavioral predictor.
// Request beats are sent in random bursts while the result side stalls on
// its own pattern. Each request is converted in the testbench and queued;
// each result beat is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        pru_pkg::t_op                            op;
        pru_pkg::t_rank                          rank;
        pru_pkg::t_elem [pru_pkg::NUM_ELEMS-1:0] elem;
    } t_conv_req;

    typedef struct packed {
        pru_pkg::t_rank                          rank;
        pru_pkg::t_elem [pru_pkg::NUM_ELEMS-1:0] elem;
        logic                                    err;
    } t_conv_res;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PERIODIC,
        SINK_BURSTY
    } t_sink_mode;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int unsigned POS_WEIGHT [pru_pkg::NUM_ELEMS] =
        '{40320, 5040, 720, 120, 24, 6, 2, 1, 1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    pru_in_if  in_if ();
    pru_out_if out_if ();

    t_conv_res  conversion_q [$];
    int         n_errors    = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;

    t_sink_mode sink_mode      = SINK_ALWAYS;
    int         sink_mode_left = 0;
    int         sink_hold_left = 0;
    logic       sink_hold_val  = 1'b1;
    int         sink_cycle     = 0;

    permutation_rank_unrank_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // rank: smaller-later counts times factorial weights
    // unrank: factoradic digits pick among unused values
    function automatic t_conv_res cantor_convert(input t_conv_req r);
        t_conv_res     res;
        int unsigned   acc;
        int unsigned   cnt;
        int unsigned   rem;
        int unsigned   pick;
        int unsigned   seen;
        int            chosen;
        logic [pru_pkg::NUM_ELEMS-1:0] used;
        res = '0;
        if (r.op == pru_pkg::OP_RANK) begin
            acc = 0;
            for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) begin
                cnt = 0;
                for (int j = i + 1; j < pru_pkg::NUM_ELEMS; j++) begin
                    if (r.elem[j] < r.elem[i]) cnt++;
                end
                acc += cnt * POS_WEIGHT[i];
            end
            res.rank = pru_pkg::t_rank'(acc);
        end else if (r.rank > pru_pkg::MAX_RANK) begin
            res.err = 1'b1;
        end else begin
            rem  = r.rank;
            used = '0;
            for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) begin
                pick   = rem / POS_WEIGHT[i];
                rem    = rem % POS_WEIGHT[i];
                seen   = 0;
                chosen = 0;
                for (int j = 0; j < pru_pkg::NUM_ELEMS; j++) begin
                    if (!used[j]) begin
                        if (seen == pick) begin
                            chosen = j;
                            break;
                        end
                        seen++;
                    end
                end
                used[chosen] = 1'b1;
                res.elem[i]  = pru_pkg::t_elem'(chosen + 1);
            end
        end
        return res;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // request capture and result check
    always @(posedge i_clk) begin : scoreboard
        t_conv_req req;
        t_conv_res want;
        t_conv_res got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                req.op      = pru_pkg::t_op'(in_if.operation);
                req.rank    = in_if.rank_in;
                req.elem[0] = in_if.elem0_in;
                req.elem[1] = in_if.elem1_in;
                req.elem[2] = in_if.elem2_in;
                req.elem[3] = in_if.elem3_in;
                req.elem[4] = in_if.elem4_in;
                req.elem[5] = in_if.elem5_in;
                req.elem[6] = in_if.elem6_in;
                req.elem[7] = in_if.elem7_in;
                req.elem[8] = in_if.elem8_in;
                conversion_q = {conversion_q, cantor_convert(req)};
            end
            if (out_if.valid && out_if.ready) begin
                got.rank    = out_if.rank_out;
                got.elem[0] = out_if.elem0_out;
                got.elem[1] = out_if.elem1_out;
                got.elem[2] = out_if.elem2_out;
                got.elem[3] = out_if.elem3_out;
                got.elem[4] = out_if.elem4_out;
                got.elem[5] = out_if.elem5_out;
                got.elem[6] = out_if.elem6_out;
                got.elem[7] = out_if.elem7_out;
                got.elem[8] = out_if.elem8_out;
                got.err     = out_if.rank_error;
                if (conversion_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result beat, expected none actual rank %0d err %0b",
                             $time, got.rank, got.err);
                end else begin
                    want = conversion_q.pop_front();
                    report_field("rank_out", want.rank, got.rank);
                    for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) begin
                        report_field($sformatf("elem%0d_out", i), want.elem[i], got.elem[i]);
                    end
                    report_field("rank_error", want.err, got.err);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("permutation_rank_unrank_core: mismatch");
                $finish;
            end
        end
    end

    // result-side backpressure in four randomly chosen modes
    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = t_sink_mode'($urandom_range(SINK_ALWAYS, SINK_BURSTY));
            sink_mode_left = $urandom_range(32, 200);
        end
        sink_mode_left--;
        sink_cycle++;
        case (sink_mode)
            SINK_ALWAYS: begin
                out_if.ready <= 1'b1;
            end
            SINK_RANDOM: begin
                out_if.ready <= 1'($urandom_range(0, 1));
            end
            SINK_PERIODIC: begin
                out_if.ready <= (sink_cycle % 5) != 0;
            end
            default: begin
                if (sink_hold_left == 0) begin
                    sink_hold_val  = ~sink_hold_val;
                    sink_hold_left = sink_hold_val ? $urandom_range(1, 12)
                                                   : $urandom_range(1, 20);
                end
                sink_hold_left--;
                out_if.ready <= sink_hold_val;
            end
        endcase
    end

    task automatic send_beat(input t_conv_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.operation <= r.op;
        in_if.rank_in   <= r.rank;
        in_if.elem0_in  <= r.elem[0];
        in_if.elem1_in  <= r.elem[1];
        in_if.elem2_in  <= r.elem[2];
        in_if.elem3_in  <= r.elem[3];
        in_if.elem4_in  <= r.elem[4];
        in_if.elem5_in  <= r.elem[5];
        in_if.elem6_in  <= r.elem[6];
        in_if.elem7_in  <= r.elem[7];
        in_if.elem8_in  <= r.elem[8];
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (conversion_q.size() != 0) @(posedge i_clk);
    endtask

    // nine decimal digits, leading digit is position 0
    function automatic t_conv_req rank_req(input int unsigned digits);
        t_conv_req r;
        r.op   = pru_pkg::OP_RANK;
        r.rank = pru_pkg::t_rank'($urandom);
        for (int i = pru_pkg::NUM_ELEMS - 1; i >= 0; i--) begin
            r.elem[i] = pru_pkg::t_elem'(digits % 10);
            digits    = digits / 10;
        end
        return r;
    endfunction

    function automatic t_conv_req unrank_req(input int unsigned value);
        t_conv_req r;
        r.op   = pru_pkg::OP_UNRANK;
        r.rank = pru_pkg::t_rank'(value);
        for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) r.elem[i] = pru_pkg::t_elem'($urandom);
        return r;
    endfunction

    task automatic test_rank_directed();
        t_conv_req r;
        send_beat(rank_req(123456789));
        send_beat(rank_req(987654321));
        send_beat(rank_req(912345678));
        send_beat(rank_req(213456789));
        send_beat(rank_req(123456798));
        send_beat(rank_req(192837465));
        // duplicated elements
        send_beat(rank_req(111111111));
        send_beat(rank_req(999999999));
        send_beat(rank_req(998877661));
        // values outside 1..9
        r = rank_req(0);
        for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) r.elem[i] = (i % 2) ? '1 : '0;
        send_beat(r);
        for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) r.elem[i] = pru_pkg::t_elem'(15 - i);
        send_beat(r);
    endtask

    task automatic test_unrank_directed();
        send_beat(unrank_req(0));
        send_beat(unrank_req(1));
        send_beat(unrank_req(2));
        send_beat(unrank_req(40319));
        send_beat(unrank_req(40320));
        send_beat(unrank_req(181440));
        send_beat(unrank_req(pru_pkg::MAX_RANK - 1));
        send_beat(unrank_req(pru_pkg::MAX_RANK));
        // rank too large
        send_beat(unrank_req(pru_pkg::MAX_RANK + 1));
        send_beat(unrank_req(2 ** pru_pkg::RANK_W - 1));
    endtask

    task automatic test_random_permutations(input int count);
        t_conv_req      r;
        pru_pkg::t_elem tmp;
        int             k;
        for (int n = 0; n < count; n++) begin
            r = rank_req(123456789);
            for (int i = pru_pkg::NUM_ELEMS - 1; i > 0; i--) begin
                k         = $urandom_range(0, i);
                tmp       = r.elem[i];
                r.elem[i] = r.elem[k];
                r.elem[k] = tmp;
            end
            send_beat(r);
        end
    endtask

    task automatic test_random_ranks(input int count);
        int unsigned value;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       value = $urandom_range(0, 30);
                1:       value = pru_pkg::MAX_RANK - $urandom_range(0, 30);
                default: value = $urandom_range(0, pru_pkg::MAX_RANK);
            endcase
            send_beat(unrank_req(value));
        end
    endtask

    task automatic test_duplicate_elems(input int count);
        t_conv_req r;
        for (int n = 0; n < count; n++) begin
            r = rank_req(0);
            for (int i = 0; i < pru_pkg::NUM_ELEMS; i++) begin
                r.elem[i] = pru_pkg::t_elem'($urandom_range(1, 9));
            end
            send_beat(r);
        end
    endtask

    task automatic test_noise(input int count);
        t_conv_req r;
        for (int n = 0; n < count; n++) begin
            r      = unrank_req($urandom_range(0, 2 ** pru_pkg::RANK_W - 1));
            r.op   = pru_pkg::t_op'($urandom_range(0, 1));
            send_beat(r);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.operation    = pru_pkg::OP_RANK;
        in_if.rank_in      = '0;
        in_if.elem0_in     = '0;
        in_if.elem1_in     = '0;
        in_if.elem2_in     = '0;
        in_if.elem3_in     = '0;
        in_if.elem4_in     = '0;
        in_if.elem5_in     = '0;
        in_if.elem6_in     = '0;
        in_if.elem7_in     = '0;
        in_if.elem8_in     = '0;
        out_if.ready       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_rank_directed();
        test_unrank_directed();
        test_random_permutations(500);
        hold_until_drained();
        test_random_ranks(500);
        test_duplicate_elems(300);
        hold_until_drained();
        test_noise(500);

        hold_until_drained();
        repeat (pru_pkg::PIPE_DEPTH + 4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("permutation_rank_unrank_core: match");
        end else begin
            $display("permutation_rank_unrank_core: mismatch");
        end
        $finish;
    end

endmodule
